@@ rtl/vlsd_pkg.sv @@
`default_nettype none
package vlsd_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_X_ORIGIN       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_ORIGIN       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAW_LINE_WIDTH = 2'd2;

  localparam logic [7:0] X_ORIGIN_RST       = 8'd50;
  localparam logic [7:0] Y_ORIGIN_RST       = 8'd50;
  localparam logic [7:0] RAW_LINE_WIDTH_RST = 8'd200;

  localparam logic [7:0] HDR_RAW = 8'd0;
  localparam logic [7:0] HDR_RLE = 8'd1;

  typedef enum logic [1:0] {
    KIND_RUN       = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_BAD_HDR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_RLE_ROW    = 3'd1,
    PH_RLE_LEN    = 3'd2,
    PH_RLE_COUNT  = 3'd3,
    PH_RLE_COLOUR = 3'd4,
    PH_RAW_ROW    = 3'd5,
    PH_RAW_PIXEL  = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] column;
    logic [7:0]  row;
    logic [7:0]  run_len;
    logic [7:0]  colour;
  } cmd_t;

  localparam int unsigned OutDataW = 48;

endpackage
`default_nettype wire

@@ rtl/vlsd_front.sv @@
`default_nettype none
module vlsd_front
  import vlsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       buffer_last,
  input  wire logic [7:0] raw_line_width,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] col_r, col_nxt;
  logic        start_r, start_nxt;
  logic        drop_r, drop_nxt;
  logic [7:0]  rem_dec;

  assign rem_dec = rem_r - 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire && !drop_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (data_byte == HDR_RLE) begin
            phase_nxt = PH_RLE_ROW;
          end else if (data_byte == HDR_RAW) begin
            phase_nxt = PH_RAW_ROW;
          end
        end
        PH_RLE_ROW:    phase_nxt = PH_RLE_LEN;
        PH_RLE_LEN:    phase_nxt = (data_byte == 8'd0) ? PH_HEADER : PH_RLE_COUNT;
        PH_RLE_COUNT:  phase_nxt = (rem_dec == 8'd0) ? PH_HEADER : PH_RLE_COLOUR;
        PH_RLE_COLOUR: phase_nxt = (rem_dec == 8'd0) ? PH_HEADER : PH_RLE_COUNT;
        PH_RAW_ROW: begin
          if ((data_byte == 8'd0 && !start_r) || raw_line_width == 8'd0) begin
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_RAW_PIXEL;
          end
        end
        PH_RAW_PIXEL:  phase_nxt = (rem_dec == 8'd0) ? PH_HEADER : PH_RAW_PIXEL;
        default:       phase_nxt = PH_HEADER;
      endcase
    end
  end

  // datapath and request outputs
  always_comb begin
    row_nxt   = row_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    drop_nxt  = drop_r;
    cmd_valid = 1'b0;
    cmd       = '{kind: KIND_RUN, column: col_r, row: row_r, run_len: 8'd0,
                  colour: data_byte};
    if (fire) begin
      if (drop_r) begin
        if (buffer_last) begin
          drop_nxt  = 1'b0;
          start_nxt = 1'b1;
        end
      end else begin
        start_nxt = buffer_last;
        case (phase_r)
          PH_HEADER: begin
            if (data_byte == HDR_RAW) begin
              if (!buffer_last) start_nxt = start_r;
            end else if (data_byte != HDR_RLE) begin
              cmd_valid = 1'b1;
              cmd.kind  = KIND_BAD_HDR;
            end
          end
          PH_RLE_ROW: row_nxt = data_byte;
          PH_RLE_LEN: begin
            rem_nxt = data_byte;
            col_nxt = 16'd0;
          end
          PH_RLE_COUNT: begin
            pend_nxt = data_byte;
            rem_nxt  = rem_dec;
          end
          PH_RLE_COLOUR: begin
            rem_nxt = rem_dec;
            if (pend_r != 8'd0) begin
              cmd_valid   = 1'b1;
              cmd.run_len = pend_r;
              col_nxt     = col_r + 16'(pend_r);
            end
          end
          PH_RAW_ROW: begin
            if (data_byte == 8'd0 && !start_r) begin
              cmd_valid  = 1'b1;
              cmd.kind   = KIND_FRAME_END;
              cmd.colour = 8'd0;
              if (!buffer_last) drop_nxt = 1'b1;
            end else begin
              row_nxt = data_byte;
              col_nxt = 16'd0;
              rem_nxt = raw_line_width;
            end
          end
          PH_RAW_PIXEL: begin
            cmd_valid   = 1'b1;
            cmd.run_len = 8'd1;
            col_nxt     = col_r + 16'd1;
            rem_nxt     = rem_dec;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      row_r   <= 8'd0;
      rem_r   <= 8'd0;
      pend_r  <= 8'd0;
      col_r   <= 16'd0;
      start_r <= 1'b1;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vlsd_queue.sv @@
`default_nettype none
module vlsd_queue
  import vlsd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            slot_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CntW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vlsd_back.sv @@
`default_nettype none
module vlsd_back
  import vlsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire cmd_t                head_cmd,
  output logic                     pop,
  input  wire logic [7:0]          x_origin,
  input  wire logic [7:0]          y_origin,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  output logic [1:0]               out_tuser
);

  logic                valid_r, valid_nxt;
  logic [OutDataW-1:0] data_r, data_nxt;
  logic [1:0]          user_r, user_nxt;
  logic [15:0]         start_x;
  logic [8:0]          screen_y;

  assign pop = head_valid && (!valid_r || out_tready);

  always_comb begin
    start_x  = 16'd0;
    screen_y = 9'd0;
    if (head_cmd.kind == KIND_RUN) begin
      start_x  = head_cmd.column + 16'(x_origin);
      screen_y = 9'(head_cmd.row) + 9'(y_origin);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    if (pop) begin
      valid_nxt = 1'b1;
      data_nxt  = {7'd0, head_cmd.colour, head_cmd.run_len, screen_y, start_x};
      user_nxt  = head_cmd.kind;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

@@ rtl/video_line_stream_decoder_unit.sv @@
// A result's command is written into the command queue at the edge accepting its byte, then registered to out_*.
// Throughput: one byte per cycle; in_tready drops only when the command queue
// between parser and output stage is full (QUEUE_DEPTH entries, output stalled).
// Reset (rst_n low, synchronous): parser back to header, queue and output emptied,
// x/y origin 50, raw line width 200.
`default_nettype none
module video_line_stream_decoder_unit
  import vlsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [7:0] data_byte
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [15:0] start_x, [24:16] screen_y, [32:25] run_length, [40:33] pixel_colour
  output logic [OutDataW-1:0]      out_tdata,
  output logic [1:0]               out_tuser,  // [1:0] result_kind
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [7:0]          cfg_data
);

  logic [7:0] x_origin_r, y_origin_r, raw_w_r;
  logic       q_full, q_pop, q_valid, cmd_valid, fire;
  cmd_t       cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      y_origin_r <= Y_ORIGIN_RST;
      raw_w_r    <= RAW_LINE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_ORIGIN:       x_origin_r <= cfg_data;
        CFG_Y_ORIGIN:       y_origin_r <= cfg_data;
        CFG_RAW_LINE_WIDTH: raw_w_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  vlsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .data_byte      (in_tdata),
    .buffer_last    (in_tlast),
    .raw_line_width (raw_w_r),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  vlsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  vlsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .x_origin   (x_origin_r),
    .y_origin   (y_origin_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

@@ rtl/vlsd_checker.sv @@
`default_nettype none
module vlsd_checker
  import vlsd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic [1:0]          out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FRAME_END |-> out_tdata == '0)
    else $error("frame end carries payload");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_RUN |-> out_tdata[32:25] != 8'd0)
    else $error("pixel run of length zero");

endmodule

bind video_line_stream_decoder_unit vlsd_checker u_vlsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

@@ tb/tb_video_line_stream_decoder_unit.sv @@
module tb_video_line_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vlsd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PrintCap = 200;

  typedef struct {
    kind_t       kind;
    logic [15:0] start_x;
    logic [8:0]  screen_y;
    logic [7:0]  run_len;
    logic [7:0]  colour;
  } pixel_run_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [1:0]          out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_X_ORIGIN;
  logic [7:0]          cfg_data = '0;

  int unsigned send_gap_pct = 7;
  int unsigned recv_gap_pct = 57;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // decoder shadow state
  logic [7:0]  x_org = X_ORIGIN_RST;
  logic [7:0]  y_org = Y_ORIGIN_RST;
  logic [7:0]  raw_width = RAW_LINE_WIDTH_RST;
  phase_t      parse_ph = PH_HEADER;
  logic [7:0]  cur_row = '0;
  logic [7:0]  bytes_left = '0;
  logic [7:0]  run_count = '0;
  logic [15:0] cur_column = '0;
  logic        buf_start = 1'b1;
  logic        drop_rest = 1'b0;
  pixel_run_t  expected_runs[$];

  logic [7:0]  buffer_bytes[$];
  int          split_at = -1;

  video_line_stream_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void queue_run(input logic [7:0] len, input logic [7:0] colour);
    pixel_run_t r;
    r.kind = KIND_RUN;
    r.start_x = cur_column + 16'(x_org);
    r.screen_y = {1'b0, cur_row} + {1'b0, y_org};
    r.run_len = len;
    r.colour = colour;
    expected_runs.push_back(r);
    cur_column = cur_column + 16'(len);
  endfunction

  function automatic void queue_marker(input kind_t kind, input logic [7:0] colour);
    pixel_run_t r;
    r.kind = kind;
    r.start_x = '0;
    r.screen_y = '0;
    r.run_len = '0;
    r.colour = colour;
    expected_runs.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic next_start;
    next_start = last;
    if (drop_rest) begin
      if (last) begin
        drop_rest = 1'b0;
        buf_start = 1'b1;
      end
      return;
    end
    case (parse_ph)
      PH_HEADER: begin
        if (b == HDR_RLE) begin
          parse_ph = PH_RLE_ROW;
        end else if (b == HDR_RAW) begin
          parse_ph = PH_RAW_ROW;
          // raw header keeps buffer-start flag for the row byte
          if (!last) next_start = buf_start;
        end else begin
          queue_marker(KIND_BAD_HDR, b);
        end
      end
      PH_RLE_ROW: begin
        cur_row = b;
        parse_ph = PH_RLE_LEN;
      end
      PH_RLE_LEN: begin
        bytes_left = b;
        cur_column = '0;
        parse_ph = (b == 8'd0) ? PH_HEADER : PH_RLE_COUNT;
      end
      PH_RLE_COUNT: begin
        run_count = b;
        bytes_left = bytes_left - 8'd1;
        parse_ph = (bytes_left == 8'd0) ? PH_HEADER : PH_RLE_COLOUR;
      end
      PH_RLE_COLOUR: begin
        bytes_left = bytes_left - 8'd1;
        if (run_count != 8'd0) queue_run(run_count, b);
        parse_ph = (bytes_left == 8'd0) ? PH_HEADER : PH_RLE_COUNT;
      end
      PH_RAW_ROW: begin
        if (b == 8'd0 && !buf_start) begin
          queue_marker(KIND_FRAME_END, 8'd0);
          parse_ph = PH_HEADER;
          if (!last) drop_rest = 1'b1;
        end else begin
          cur_row = b;
          cur_column = '0;
          bytes_left = raw_width;
          parse_ph = (raw_width == 8'd0) ? PH_HEADER : PH_RAW_PIXEL;
        end
      end
      PH_RAW_PIXEL: begin
        queue_run(8'd1, b);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) parse_ph = PH_HEADER;
      end
      default: parse_ph = PH_HEADER;
    endcase
    buf_start = next_start;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("%0t mismatch %s: want %0h got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    pixel_run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch("result with none pending", '0, out_tdata[15:0]);
      end else begin
        want = expected_runs.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("result_kind", 16'(want.kind), 16'(out_tuser));
        if (out_tdata[15:0] !== want.start_x)
          report_mismatch("start_x", want.start_x, out_tdata[15:0]);
        if (out_tdata[24:16] !== want.screen_y)
          report_mismatch("screen_y", 16'(want.screen_y), 16'(out_tdata[24:16]));
        if (out_tdata[32:25] !== want.run_len)
          report_mismatch("run_length", 16'(want.run_len), 16'(out_tdata[32:25]));
        if (out_tdata[40:33] !== want.colour)
          report_mismatch("pixel_colour", 16'(want.colour), 16'(out_tdata[40:33]));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    decode_byte(b, last);
  endtask

  task automatic send_buffer(input logic [7:0] data_q[$]);
    foreach (data_q[i]) send_byte(data_q[i], i == data_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_X_ORIGIN:       x_org = v;
      CFG_Y_ORIGIN:       y_org = v;
      CFG_RAW_LINE_WIDTH: raw_width = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w);
    wait_drained();
    cfg_put(CFG_X_ORIGIN, x);
    cfg_put(CFG_Y_ORIGIN, y);
    cfg_put(CFG_RAW_LINE_WIDTH, w);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_record();
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 40) begin
      buffer_bytes.push_back(HDR_RLE);
      buffer_bytes.push_back(8'($urandom));
      if ($urandom_range(19) == 0) len = $urandom_range(255);
      else len = 2 * $urandom_range(6) + (($urandom_range(9) == 0) ? 1 : 0);
      buffer_bytes.push_back(8'(len));
      for (k = 0; k < len; k++) begin
        if (k % 2 == 0 && $urandom_range(7) == 0) buffer_bytes.push_back(8'd0);
        else buffer_bytes.push_back(8'($urandom));
      end
    end else if (pick < 70) begin
      buffer_bytes.push_back(HDR_RAW);
      buffer_bytes.push_back(($urandom_range(5) == 0) ? 8'd0 : 8'($urandom));
      for (k = 0; k < raw_width; k++) buffer_bytes.push_back(8'($urandom));
    end else if (pick < 80) begin
      buffer_bytes.push_back(HDR_RAW);
      buffer_bytes.push_back(8'd0);
    end else if (pick < 90) begin
      buffer_bytes.push_back(8'($urandom_range(255, 2)));
    end else begin
      repeat ($urandom_range(4, 1)) buffer_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void build_buffer();
    buffer_bytes.delete();
    repeat ($urandom_range(4, 1)) add_record();
    // sometimes cut the buffer early so records straddle buffers
    split_at = ($urandom_range(4) == 0) ? int'($urandom_range(buffer_bytes.size() - 1)) : -1;
  endfunction

  task automatic test_run_length_lines();
    // run of 4, zero-count pair, dangling count byte
    send_buffer('{HDR_RLE, 8'd3, 8'd5, 8'd4, 8'd7, 8'd0, 8'd9, 8'd2});
    // empty line
    send_buffer('{HDR_RLE, 8'd9, 8'd0});
  endtask

  task automatic test_headers_and_frame_end();
    // bad headers, then frame end on the buffer's last byte (no drop)
    send_buffer('{8'hFF, 8'h02, HDR_RAW, 8'd0});
    // frame end mid-buffer drops the rest
    send_buffer('{8'hFE, HDR_RAW, 8'd0, 8'h55, 8'hAA});
  endtask

  task automatic test_raw_lines();
    send_buffer('{HDR_RAW, 8'd255, 8'h11, 8'h22});
  endtask

  task automatic test_zero_width();
    // row 0 at buffer start is a line, not a frame end
    send_buffer('{HDR_RAW, 8'd0, HDR_RLE, 8'd9, 8'd2, 8'd3, 8'd1});
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_buffer();
      foreach (buffer_bytes[i]) begin
        if (sent < n_bytes) begin
          send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1 || i == split_at ||
                    sent == n_bytes - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_config(8'($urandom), 8'($urandom), 8'd40);
    hold_cycles = 60;
    buffer_bytes.delete();
    buffer_bytes.push_back(HDR_RAW);
    buffer_bytes.push_back(8'd17);
    repeat (40) buffer_bytes.push_back(8'($urandom));
    send_buffer(buffer_bytes);
  endtask

  task automatic test_drain_pause();
    send_byte(HDR_RLE, 1'b0);
    send_byte(8'd7, 1'b0);
    send_byte(8'd6, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'h21, 1'b0);
    wait_drained();
    send_byte(8'd4, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'h63, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 7;
    recv_gap_pct = 57;
    test_run_length_lines();
    test_headers_and_frame_end();
    test_random_traffic(300);
    set_config(8'd255, 8'd255, 8'd2);
    test_raw_lines();
    set_config(8'd0, 8'd0, 8'd0);
    test_zero_width();

    send_gap_pct = 57;
    recv_gap_pct = 7;
    set_config(8'd0, 8'd0, 8'd1);
    test_random_traffic(300);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_config(8'($urandom), 8'($urandom), 8'd255);
    test_random_traffic(250);
    set_config(8'($urandom), 8'($urandom), 8'($urandom_range(12, 1)));
    test_random_traffic(250);
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vlsd_pkg.sv
rtl/vlsd_front.sv
rtl/vlsd_queue.sv
rtl/vlsd_back.sv
rtl/video_line_stream_decoder_unit.sv
rtl/vlsd_checker.sv
tb/tb_video_line_stream_decoder_unit.sv
